### sv/pdrl_pkg.sv
// Shared types and constants for the ping delay rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package pdrl_pkg;

   typedef enum logic [1:0] {
      COND_NORMAL = 2'd0,
      COND_BAD    = 2'd1,
      COND_GOOD   = 2'd2,
      COND_DISC   = 2'd3
   } cond_type;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_PING   = 2'd1,
      MODE_EVAL   = 2'd2,
      MODE_IGNORE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_SPEED_UP   = 3'd0,
      REG_SPEED_DOWN = 3'd1,
      REG_BAD_TH     = 3'd2,
      REG_GOOD_TH    = 3'd3,
      REG_USER_CAP   = 3'd4
   } reg_type;

   typedef struct packed {
      logic [9:0]  speed_up;
      logic [6:0]  speed_down;
      logic [15:0] bad_th;
      logic [15:0] good_th;
      logic [31:0] user_cap;
   } cfg_type;

   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int DELAY_W    = 16;
   localparam int SUM_W      = 19;
   localparam int LIMIT_W    = 32;
   localparam int PROD_DN_W  = 15;
   localparam int PROD_UP_W  = 22;

   localparam logic [SUM_W-1:0]   SUM_MAX    = 19'h7FFFF;
   localparam logic [LIMIT_W-1:0] RATE_FLOOR = 32'd10;
   localparam logic [LIMIT_W-1:0] RATE_BASE  = 32'd200;
   localparam logic [LIMIT_W-1:0] RATE_CEIL  = 32'd2048;
   localparam logic [6:0]         PCT_FULL   = 7'd100;

   // Reciprocals of 100, exact over the product ranges that reach them.
   localparam int          DIV100_DN_SHIFT = 22;
   localparam logic [15:0] DIV100_DN_MULT  = 16'd41944;
   localparam int          DIV100_UP_SHIFT = 29;
   localparam logic [22:0] DIV100_UP_MULT  = 23'd5368710;

   localparam cfg_type CFG_RESET = '{
      speed_up:   10'd20,
      speed_down: 7'd10,
      bad_th:     16'd300,
      good_th:    16'd100,
      user_cap:   32'hFFFF_FFFF
   };

endpackage

`default_nettype wire

### sv/ping_delay_rate_limiter_top.sv
// Top level of the ping delay rate limiter: input stage, round state and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  mode, ping_ok, delay, current limits
//   rsp      out        rsp_valid / rsp_stall  condition, apply, new limits, average
//   csr      in         psel/penable/pwrite    five configuration registers
//
// One item is taken per cycle while req_stall is low; its result passes the input register
// and then the result register, and is taken at an edge where rsp_stall is low.
// The input register and the result register bound the path, whose depth is set
// by the trimmed-mean reciprocal multiply and the divide-by-100 multiplies.
// Reset is synchronous: round state and configuration return to their defaults.
// While rsp_stall holds a result, one more beat is taken into the input register.
`timescale 1ns / 1ps
`default_nettype none

module ping_delay_rate_limiter_top
   import pdrl_pkg::*;
#(
   parameter int ROUND_PINGS   = 5,
   parameter int TIMEOUT_DELAY = 1000
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_mode,
   input  wire logic                      req_ping_ok,
   input  wire logic [DELAY_W-1:0]        req_delay,
   input  wire logic [LIMIT_W-1:0]        req_current_upload_limit,
   input  wire logic [LIMIT_W-1:0]        req_current_download_limit,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_condition,
   output logic                           rsp_apply_limits,
   output logic [LIMIT_W-1:0]             rsp_new_upload_limit,
   output logic [LIMIT_W-1:0]             rsp_new_download_limit,
   output logic signed [16:0]             rsp_average_delay,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [ADDR_W-1:0]         paddr,
   input  wire logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]              prdata,
   output logic                           pready
);

   localparam int NUM_W      = 21;
   localparam int MAG_W      = 20;
   localparam int DIVISOR    = ROUND_PINGS - 2;
   localparam int MEAN_SHIFT = 24;
   localparam int MULT_W     = 25;
   localparam int WIDE_W     = MAG_W + MULT_W;
   localparam logic [MULT_W-1:0] MEAN_MULT =
      MULT_W'((2 ** MEAN_SHIFT + DIVISOR - 1) / DIVISOR);
   localparam logic [DELAY_W-1:0]     TIMEOUT_MIN  = DELAY_W'(TIMEOUT_DELAY);
   localparam logic signed [NUM_W-1:0] TIMEOUT_MEAN = NUM_W'(TIMEOUT_DELAY);
   localparam logic signed [NUM_W-1:0] SHOW_MAX     = 21'sd65535;
   localparam logic signed [NUM_W-1:0] SHOW_MIN     = -21'sd65535;

   cfg_type cfg;

   pdrl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input stage.
   logic                 s1_valid_ff;
   mode_type             s1_mode_ff;
   logic                 s1_ok_ff;
   logic [DELAY_W-1:0]   s1_delay_ff;
   logic [LIMIT_W-1:0]   s1_cur_up_ff;
   logic [LIMIT_W-1:0]   s1_cur_dn_ff;
   logic [PROD_DN_W-1:0] s1_prod_dn_ff;
   logic [PROD_UP_W-1:0] s1_prod_up_ff;
   logic [PROD_DN_W-1:0] prod_dn_in;
   logic [PROD_UP_W-1:0] prod_up_in;
   logic [6:0]           dn_pct;
   logic                 req_take;
   logic                 advance;

   // Only limits up to the base or maximum reach the scaled products.
   assign dn_pct     = (cfg.speed_down > PCT_FULL) ? PCT_FULL : cfg.speed_down;
   assign prod_dn_in = PROD_DN_W'(req_current_upload_limit[7:0]) *
                       PROD_DN_W'(PCT_FULL - dn_pct);
   assign prod_up_in = PROD_UP_W'(req_current_upload_limit[11:0]) *
                       PROD_UP_W'(11'(PCT_FULL) + 11'(cfg.speed_up));

   assign advance   = s1_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff    <= mode_type'(req_mode);
         s1_ok_ff      <= req_ping_ok;
         s1_delay_ff   <= req_delay;
         s1_cur_up_ff  <= req_current_upload_limit;
         s1_cur_dn_ff  <= req_current_download_limit;
         s1_prod_dn_ff <= prod_dn_in;
         s1_prod_up_ff <= prod_up_in;
      end
   end

   // Round state.
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [DELAY_W-1:0] max_ff;
   logic [DELAY_W-1:0] max_in;
   logic [DELAY_W-1:0] min_ff;
   logic [DELAY_W-1:0] min_in;
   cond_type           pending_ff;
   cond_type           pending_in;
   logic [SUM_W:0]     sum_raw;

   assign sum_raw = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(s1_delay_ff);

   // Trimmed mean, truncated toward zero by dividing the magnitude.
   logic signed [NUM_W-1:0] num;
   logic signed [NUM_W-1:0] num_neg;
   logic [MAG_W-1:0]        num_mag;
   logic [WIDE_W-1:0]       mean_wide;
   logic [MAG_W-1:0]        mean_mag;
   logic signed [NUM_W-1:0] mean;
   logic                    is_bad;
   logic                    is_good;
   logic signed [16:0]      shown;
   cond_type                cond_in;
   logic                    apply_in;
   logic [LIMIT_W-1:0]      new_up_in;

   assign num       = NUM_W'(sum_ff) - NUM_W'(max_ff) - NUM_W'(min_ff);
   assign num_neg   = -num;
   assign num_mag   = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
   assign mean_wide = WIDE_W'(num_mag) * WIDE_W'(MEAN_MULT);
   assign mean_mag  = mean_wide[MEAN_SHIFT+MAG_W-1:MEAN_SHIFT];
   assign mean      = num[NUM_W-1] ? -NUM_W'(mean_mag) : NUM_W'(mean_mag);

   assign is_bad  = (mean < 0) || (mean >= $signed(NUM_W'(cfg.bad_th)));
   assign is_good = ~is_bad && (mean < $signed(NUM_W'(cfg.good_th)));

   always_comb begin
      if (s1_mode_ff != MODE_EVAL) begin
         shown = '0;
      end else if (mean > SHOW_MAX) begin
         shown = SHOW_MAX[16:0];
      end else if (mean < SHOW_MIN) begin
         shown = SHOW_MIN[16:0];
      end else begin
         shown = mean[16:0];
      end
   end

   always_comb begin
      sum_in     = sum_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      pending_in = pending_ff;
      cond_in    = COND_NORMAL;
      case (s1_mode_ff)
         MODE_START: begin
            sum_in = '0;
            max_in = '0;
            min_in = TIMEOUT_MIN;
         end
         MODE_PING: begin
            if (s1_ok_ff) begin
               sum_in = (sum_raw > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_raw[SUM_W-1:0];
               max_in = (max_ff < s1_delay_ff) ? s1_delay_ff : max_ff;
               min_in = (min_ff > s1_delay_ff) ? s1_delay_ff : min_ff;
            end
         end
         MODE_EVAL: begin
            // A verdict is confirmed by the second evaluation in a row.
            if (is_bad) begin
               if (pending_ff != COND_BAD) begin
                  pending_in = COND_BAD;
               end else begin
                  pending_in = COND_NORMAL;
                  cond_in    = (mean == TIMEOUT_MEAN) ? COND_DISC : COND_BAD;
               end
            end else if (is_good) begin
               if (pending_ff != COND_GOOD) begin
                  pending_in = COND_GOOD;
               end else begin
                  pending_in = COND_NORMAL;
                  cond_in    = COND_GOOD;
               end
            end else begin
               pending_in = COND_NORMAL;
            end
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   pdrl_adjust u_adjust (
      .cond    (cond_in),
      .cfg     (cfg),
      .cur_up  (s1_cur_up_ff),
      .prod_dn (s1_prod_dn_ff),
      .prod_up (s1_prod_up_ff),
      .apply   (apply_in),
      .new_up  (new_up_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         max_ff     <= '0;
         min_ff     <= TIMEOUT_MIN;
         pending_ff <= COND_NORMAL;
      end else if (advance) begin
         sum_ff     <= sum_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         pending_ff <= pending_in;
      end
   end

   // Result register.
   logic               rsp_valid_ff;
   cond_type           rsp_cond_ff;
   logic               rsp_apply_ff;
   logic [LIMIT_W-1:0] rsp_up_ff;
   logic [LIMIT_W-1:0] rsp_dn_ff;
   logic signed [16:0] rsp_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cond_ff  <= cond_in;
         rsp_apply_ff <= apply_in;
         rsp_up_ff    <= new_up_in;
         rsp_dn_ff    <= s1_cur_dn_ff;
         rsp_avg_ff   <= shown;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_condition          = rsp_cond_ff;
   assign rsp_apply_limits       = rsp_apply_ff;
   assign rsp_new_upload_limit   = rsp_up_ff;
   assign rsp_new_download_limit = rsp_dn_ff;
   assign rsp_average_delay      = rsp_avg_ff;

`ifndef SYNTHESIS
   a_apply_needs_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_apply_limits) |->
      (rsp_condition == COND_BAD || rsp_condition == COND_GOOD))
      else $error("limits applied without a bad or good verdict");

   a_pending_not_disc: assert property (@(posedge clock) disable iff (reset)
      pending_ff != COND_DISC)
      else $error("pending verdict holds the disconnected code");

   a_sum_covers_max: assert property (@(posedge clock) disable iff (reset)
      sum_ff >= SUM_W'(max_ff))
      else $error("delay sum fell below the round maximum");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && rsp_stall) |=> s1_valid_ff)
      else $error("input stage dropped a beat while the result was stalled");
`endif

endmodule

`default_nettype wire

### sv/pdrl_csr.sv
// APB-style configuration registers of the ping delay rate limiter.
`timescale 1ns / 1ps
`default_nettype none

module pdrl_csr
   import pdrl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type reg_sel;
   logic    wr_en;

   assign reg_sel = reg_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SPEED_UP:   cfg_in.speed_up   = pwdata[9:0];
            REG_SPEED_DOWN: cfg_in.speed_down = pwdata[6:0];
            REG_BAD_TH:     cfg_in.bad_th     = pwdata[15:0];
            REG_GOOD_TH:    cfg_in.good_th    = pwdata[15:0];
            REG_USER_CAP:   cfg_in.user_cap   = pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SPEED_UP:   prdata = DATA_W'(cfg_ff.speed_up);
         REG_SPEED_DOWN: prdata = DATA_W'(cfg_ff.speed_down);
         REG_BAD_TH:     prdata = DATA_W'(cfg_ff.bad_th);
         REG_GOOD_TH:    prdata = DATA_W'(cfg_ff.good_th);
         REG_USER_CAP:   prdata = cfg_ff.user_cap;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### sv/pdrl_adjust.sv
// Upload limit adjustment for a confirmed bad or good verdict.
`timescale 1ns / 1ps
`default_nettype none

module pdrl_adjust
   import pdrl_pkg::*;
(
   input  wire cond_type           cond,
   input  wire cfg_type            cfg,
   input  wire logic [LIMIT_W-1:0] cur_up,
   input  wire logic [PROD_DN_W-1:0] prod_dn,
   input  wire logic [PROD_UP_W-1:0] prod_up,
   output logic                    apply,
   output logic      [LIMIT_W-1:0] new_up
);

   localparam int DN_WIDE_W = PROD_DN_W + 16;
   localparam int UP_WIDE_W = PROD_UP_W + 23;

   logic [DN_WIDE_W-1:0] dn_wide;
   logic [UP_WIDE_W-1:0] up_wide;
   logic [LIMIT_W-1:0]   dn_quot;
   logic [LIMIT_W-1:0]   up_quot;
   logic [LIMIT_W-1:0]   dn_floor;
   logic [LIMIT_W-1:0]   up_max_cap;
   logic [LIMIT_W-1:0]   up_capped;

   // Division by 100 through a reciprocal multiply.
   assign dn_wide = DN_WIDE_W'(prod_dn) * DN_WIDE_W'(DIV100_DN_MULT);
   assign up_wide = UP_WIDE_W'(prod_up) * UP_WIDE_W'(DIV100_UP_MULT);
   assign dn_quot = LIMIT_W'(dn_wide[DN_WIDE_W-1:DIV100_DN_SHIFT]);
   assign up_quot = LIMIT_W'(up_wide[UP_WIDE_W-1:DIV100_UP_SHIFT]);

   assign dn_floor   = (dn_quot < RATE_FLOOR) ? RATE_FLOOR : dn_quot;
   assign up_max_cap = (up_quot > RATE_CEIL) ? RATE_CEIL : up_quot;
   assign up_capped  = (up_max_cap > cfg.user_cap) ? cfg.user_cap : up_max_cap;

   always_comb begin
      apply  = 1'b0;
      new_up = cur_up;
      case (cond)
         COND_BAD: begin
            if (cfg.user_cap > RATE_FLOOR) begin
               apply  = 1'b1;
               new_up = (cur_up > RATE_BASE) ? RATE_BASE : dn_floor;
            end
         end
         COND_GOOD: begin
            if (cur_up < cfg.user_cap) begin
               apply  = 1'b1;
               new_up = (cur_up > RATE_CEIL) ? RATE_CEIL : up_capped;
            end
         end
         default: begin
            apply  = 1'b0;
            new_up = cur_up;
         end
      endcase
   end

endmodule

`default_nettype wire
